[hw/rtl/q931ies_pkg.sv]
// Shared types and constants for the Q.931 message element scanner.
// Depends on nothing; imported by the parser, the output queue and the top level.
package q931ies_pkg;

    localparam int MAX_MSG_BYTES_DEF = 512;
    localparam int OQ_DEPTH          = 4;
    localparam int OQ_AW             = $clog2(OQ_DEPTH);
    localparam int OQ_CW             = $clog2(OQ_DEPTH + 1);
    localparam int IN_DATA_W         = 8;
    localparam int OUT_DATA_W        = 64;

    typedef enum logic [1:0] {
        KIND_HDR    = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_VAR    = 2'd2,
        KIND_END    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_SHORT    = 3'd1,
        STAT_REF_LONG = 3'd2,
        STAT_NO_LEN   = 3'd3,
        STAT_TRUNC    = 3'd4
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  id;
        logic [8:0]  off;
        logic [7:0]  len;
        logic [15:0] cref;
        logic [1:0]  cref_len;
        logic [7:0]  msg_type;
        logic [7:0]  count;
        t_status     status;
        logic        last;
    } t_rec;

endpackage

[hw/rtl/q931_message_ie_scanner.sv]
// Top level of the Q.931 message information element scanner.
// Depends on q931ies_pkg, q931ies_parser and q931ies_outq.
//
// Input channel (s_): one message octet per beat in tdata, tlast on the final
// octet. Output channel (m_): one record per beat, kind in tuser, tlast on the
// end-of-message record. The first octets give a header record (call reference,
// its length, message type); each codeset-0 element gives an element record with
// identifier, offset from the type octet and contents length; the last octet
// adds an end record with the element count and a status.
// Throughput: one octet per cycle while s_tready is high. A record is registered
// in the record queue on the beat that completes it and leaves on m_ from there.
// An octet that yields two records (a header or element record plus the end
// record) fills two places in a four-entry record queue, drained one per cycle
// while m_tready is high; s_tready drops while more than two records wait.
// Stalling the receiver therefore back-pressures the input once three records
// wait; octets that complete no record keep flowing until then. Reset clears the
// scan state and empties the queue; the block is ready once reset is released.
module q931_message_ie_scanner import q931ies_pkg::*; #(
    parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] element_id, [16:8] element_offset, [24:17] element_length,
    // [40:25] call_reference, [42:41] call_reference_length,
    // [50:43] message_type, [58:51] element_count, [61:59] status, [63:62] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [1:0]            o_m_tuser,   // [1:0] record_kind
    output logic                  o_m_tlast
);

    logic       beat;
    logic [1:0] rec_num;
    t_rec       rec_a;
    t_rec       rec_b;
    t_rec       head;
    logic       room;

    assign beat       = i_s_tvalid && o_s_tready;
    assign o_s_tready = room;

    q931ies_parser #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_data    (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_rec_num (rec_num),
        .o_rec_a   (rec_a),
        .o_rec_b   (rec_b)
    );

    q931ies_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_num (rec_num),
        .i_rec_a    (rec_a),
        .i_rec_b    (rec_b),
        .i_pop      (o_m_tvalid && i_m_tready),
        .o_head     (head),
        .o_valid    (o_m_tvalid),
        .o_room     (room)
    );

    assign o_m_tdata = {2'b00, head.status, head.count, head.msg_type, head.cref_len,
                        head.cref, head.len, head.off, head.id};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

[hw/rtl/q931ies_parser.sv]
// Per-octet Q.931 header and information element decoder.
// Holds the scan state and emits up to two records per accepted beat.
// Depends on q931ies_pkg.
module q931ies_parser import q931ies_pkg::*; #(
    parameter int MAX_MSG_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_beat,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic [1:0] o_rec_num,
    output t_rec       o_rec_a,
    output t_rec       o_rec_b
);

    localparam int OW = $clog2(MAX_MSG_BYTES + 1);

    typedef enum logic [7:0] {
        PH_DISC    = 8'b0000_0001,
        PH_CRLEN   = 8'b0000_0010,
        PH_CRBYTES = 8'b0000_0100,
        PH_TYPE    = 8'b0000_1000,
        PH_IE_ID   = 8'b0001_0000,
        PH_IE_LEN  = 8'b0010_0000,
        PH_IE_BODY = 8'b0100_0000,
        PH_DRAIN   = 8'b1000_0000
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [OW-1:0] r_offset, n_offset;
    logic [15:0] r_ref_val,  n_ref_val;
    logic [1:0]  r_ref_len,  n_ref_len;
    logic [1:0]  r_ref_left, n_ref_left;
    logic [7:0]  r_type,     n_type;
    logic [2:0]  r_locked,   n_locked;
    logic [2:0]  r_active,   n_active;
    logic [7:0]  r_left,     n_left;
    logic [7:0]  r_cur_id,   n_cur_id;
    logic [7:0]  r_count,    n_count;
    logic        r_ref_long, n_ref_long;
    logic [7:0]  r_elem_len, n_elem_len;
    logic [8:0]  r_elem_off, n_elem_off;

    logic [8:0]  rel;
    logic [7:0]  cnt_inc;
    t_rec        rec_p;
    t_rec        rec_e;
    logic        have_p;
    logic        finish;
    t_status     end_stat;

    assign rel     = 9'(r_offset) - (9'd2 + 9'(r_ref_len));
    assign cnt_inc = (r_count == 8'hFF) ? r_count : r_count + 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_offset   = r_offset;
        n_ref_val  = r_ref_val;
        n_ref_len  = r_ref_len;
        n_ref_left = r_ref_left;
        n_type     = r_type;
        n_locked   = r_locked;
        n_active   = r_active;
        n_left     = r_left;
        n_cur_id   = r_cur_id;
        n_count    = r_count;
        n_ref_long = r_ref_long;
        n_elem_len = r_elem_len;
        n_elem_off = r_elem_off;
        have_p     = 1'b0;
        finish     = 1'b0;
        rec_p      = '0;
        rec_e      = '0;
        end_stat   = STAT_OK;
        o_rec_a    = '0;
        o_rec_b    = '0;
        o_rec_num  = 2'd0;

        if (i_beat && (r_offset < OW'(MAX_MSG_BYTES))) begin
            n_offset = r_offset + OW'(1);
            case (r_phase)
                PH_DISC: begin
                    n_phase = PH_CRLEN;
                end
                PH_CRLEN: begin
                    if (!i_last) begin
                        if (i_data[3:0] > 4'd2) begin
                            n_ref_long = 1'b1;
                            n_phase    = PH_DRAIN;
                        end else begin
                            n_ref_len  = i_data[1:0];
                            n_ref_left = i_data[1:0];
                            n_phase    = (i_data[1:0] == 2'd0) ? PH_TYPE : PH_CRBYTES;
                        end
                    end
                end
                PH_CRBYTES: begin
                    if (r_ref_len == 2'd2) begin
                        n_ref_val = {r_ref_val[7:0], i_data};
                    end else if (i_data[7]) begin
                        n_ref_val = {1'b1, 8'h00, i_data[6:0]};
                    end else begin
                        n_ref_val = {8'h00, i_data};
                    end
                    n_ref_left = r_ref_left - 2'd1;
                    if (r_ref_left == 2'd1) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type     = i_data;
                    have_p     = 1'b1;
                    rec_p.kind = KIND_HDR;
                    n_phase    = PH_IE_ID;
                end
                PH_IE_ID: begin
                    if (i_data[7:4] == 4'h9) begin
                        n_active = i_data[2:0];
                        if (!i_data[3]) begin
                            n_locked = i_data[2:0];
                        end
                    end else if (i_data[7]) begin
                        if (r_active == 3'd0) begin
                            n_count    = cnt_inc;
                            have_p     = 1'b1;
                            rec_p.kind = KIND_SINGLE;
                            rec_p.id   = i_data;
                            rec_p.off  = rel;
                        end
                        n_active = r_locked;
                    end else begin
                        n_cur_id   = i_data;
                        n_elem_off = rel;
                        n_phase    = PH_IE_LEN;
                    end
                end
                PH_IE_LEN: begin
                    n_elem_len = i_data;
                    if (i_data == 8'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_left  = i_data;
                        n_phase = PH_IE_BODY;
                    end
                end
                PH_IE_BODY: begin
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (finish) begin
                if (r_active == 3'd0) begin
                    n_count    = cnt_inc;
                    have_p     = 1'b1;
                    rec_p.kind = KIND_VAR;
                    rec_p.id   = r_cur_id;
                    rec_p.off  = n_elem_off;
                    rec_p.len  = n_elem_len;
                end
                n_active = r_locked;
                n_phase  = PH_IE_ID;
            end
        end

        rec_p.cref     = n_ref_val;
        rec_p.cref_len = n_ref_len;
        rec_p.msg_type = n_type;
        rec_p.count    = n_count;

        case (n_phase)
            PH_DISC, PH_CRLEN, PH_CRBYTES, PH_TYPE: end_stat = STAT_SHORT;
            PH_DRAIN:   end_stat = n_ref_long ? STAT_REF_LONG : STAT_OK;
            PH_IE_LEN:  end_stat = (n_active == 3'd0) ? STAT_NO_LEN : STAT_OK;
            PH_IE_BODY: end_stat = (n_active == 3'd0) ? STAT_TRUNC : STAT_OK;
            default:    end_stat = STAT_OK;
        endcase

        rec_e.kind     = KIND_END;
        rec_e.cref     = n_ref_val;
        rec_e.cref_len = n_ref_len;
        rec_e.msg_type = n_type;
        rec_e.count    = n_count;
        rec_e.status   = end_stat;
        rec_e.last     = 1'b1;

        if (i_beat) begin
            if (have_p) begin
                o_rec_a   = rec_p;
                o_rec_b   = rec_e;
                o_rec_num = i_last ? 2'd2 : 2'd1;
            end else if (i_last) begin
                o_rec_a   = rec_e;
                o_rec_num = 2'd1;
            end
        end

        if (i_beat && i_last) begin
            n_phase    = PH_DISC;
            n_offset   = '0;
            n_ref_val  = '0;
            n_ref_len  = '0;
            n_ref_left = '0;
            n_type     = '0;
            n_locked   = '0;
            n_active   = '0;
            n_left     = '0;
            n_cur_id   = '0;
            n_count    = '0;
            n_ref_long = 1'b0;
            n_elem_len = '0;
            n_elem_off = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_DISC;
            r_offset   <= '0;
            r_ref_val  <= '0;
            r_ref_len  <= '0;
            r_ref_left <= '0;
            r_type     <= '0;
            r_locked   <= '0;
            r_active   <= '0;
            r_left     <= '0;
            r_cur_id   <= '0;
            r_count    <= '0;
            r_ref_long <= 1'b0;
            r_elem_len <= '0;
            r_elem_off <= '0;
        end else begin
            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_ref_val  <= n_ref_val;
            r_ref_len  <= n_ref_len;
            r_ref_left <= n_ref_left;
            r_type     <= n_type;
            r_locked   <= n_locked;
            r_active   <= n_active;
            r_left     <= n_left;
            r_cur_id   <= n_cur_id;
            r_count    <= n_count;
            r_ref_long <= n_ref_long;
            r_elem_len <= n_elem_len;
            r_elem_off <= n_elem_off;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_phase == PH_DISC && r_offset == '0 && r_count == '0))
        else $error("scan state not cleared after last beat");

    a_two_recs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec_num == 2'd2) |-> (o_rec_b.last && !o_rec_a.last && i_last))
        else $error("second record is not the end record");

    a_offset_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_offset <= OW'(MAX_MSG_BYTES))
        else $error("octet index beyond message limit");

endmodule

[hw/rtl/q931ies_outq.sv]
// Small record queue that accepts up to two records a cycle and releases one.
// Depends on q931ies_pkg.
module q931ies_outq import q931ies_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_num,
    input  t_rec       i_rec_a,
    input  t_rec       i_rec_b,
    input  logic       i_pop,
    output t_rec       o_head,
    output logic       o_valid,
    output logic       o_room
);

    t_rec             r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr, n_wr;
    logic [OQ_AW-1:0] r_rd, n_rd;
    logic [OQ_CW-1:0] r_count, n_count;

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= OQ_CW'(OQ_DEPTH - 2));

    always_comb begin
        n_wr    = r_wr + OQ_AW'(i_push_num);
        n_rd    = r_rd + OQ_AW'(i_pop);
        n_count = r_count + OQ_CW'(i_push_num) - OQ_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_num != 2'd0) begin
            r_mem[r_wr] <= i_rec_a;
        end
        if (i_push_num == 2'd2) begin
            r_mem[r_wr + OQ_AW'(1)] <= i_rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_num != 2'd0) |-> (r_count <= OQ_CW'(OQ_DEPTH - 2)))
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("record queue underflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CW'(OQ_DEPTH))
        else $error("record queue count out of range");

endmodule
